/* design/lrupr_pkg.sv */
package lrupr_pkg;

	localparam int PAGE_W  = 16;
	localparam int SLOT_W  = 3;
	localparam int CFG_W   = 4;
	localparam int FAULT_W = 16;

	localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 4'd8;
	localparam logic [FAULT_W-1:0] FAULT_MAX       = 16'hFFFF;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COMPARE,
		ST_UPDATE
	} state_t;

	typedef struct packed {
		logic load_page;
		logic compare;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

/* design/lrupr_ctrl.sv */
module lrupr_ctrl
	import lrupr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_nxt = ST_COMPARE;
				end
			end
			ST_COMPARE: begin
				state_nxt = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (sts.out_free) begin
					state_nxt = in_valid ? ST_COMPARE : ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready      = 1'b0;
		cmd.load_page = 1'b0;
		cmd.compare   = 1'b0;
		cmd.commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready      = 1'b1;
				cmd.load_page = in_valid;
			end
			ST_COMPARE: begin
				cmd.compare = 1'b1;
			end
			ST_UPDATE: begin
				// commit and take the next reference in the same cycle
				in_ready      = sts.out_free;
				cmd.commit    = sts.out_free;
				cmd.load_page = sts.out_free & in_valid;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

endmodule

/* design/lrupr_datapath.sv */
module lrupr_datapath
	import lrupr_pkg::*;
#(
	parameter int FRAMES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [PAGE_W-1:0]  page_number,
	input  logic               cfg_valid,
	input  logic [CFG_W-1:0]   frame_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [SLOT_W-1:0]  slot,
	output logic               replaced,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [FAULT_W-1:0] fault_total
);

	localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FILL_W = $clog2(FRAMES + 1);
	localparam int CMP_W  = (FILL_W > CFG_W) ? FILL_W : CFG_W;

	localparam logic [CMP_W-1:0] FRAMES_C = CMP_W'(FRAMES);

	logic [CFG_W-1:0]   frame_count_q;
	logic [PAGE_W-1:0]  page_q;
	logic [PAGE_W-1:0]  frame_page_q [FRAMES];
	logic [IDX_W-1:0]   rank_q [FRAMES];
	logic [FILL_W-1:0]  filled_q;
	logic [FAULT_W-1:0] fault_q;

	logic [PAGE_W-1:0]  page_s1;
	logic               hit_s1;
	logic               fill_s1;
	logic [IDX_W-1:0]   slot_s1;
	logic [IDX_W-1:0]   lim_s1;
	logic [PAGE_W-1:0]  evicted_s1;

	logic               out_valid_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               replaced_q;
	logic [PAGE_W-1:0]  evicted_q;
	logic [FAULT_W-1:0] fault_out_q;

	logic [CMP_W-1:0]   limit;
	logic [FRAMES-1:0]  frame_vld;
	logic [FRAMES-1:0]  match;
	logic [FRAMES-1:0]  oldest;
	logic [FILL_W-1:0]  filled_m1;
	logic [IDX_W-1:0]   hit_idx;
	logic [IDX_W-1:0]   old_idx;
	logic [IDX_W-1:0]   hit_rank;
	logic [PAGE_W-1:0]  old_page;
	logic               any_hit;
	logic               can_fill;
	logic               do_replace;
	logic [FAULT_W-1:0] fault_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= FRAME_COUNT_RST;
		end else if (cfg_valid) begin
			frame_count_q <= frame_count;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_page) begin
			page_q <= page_number;
		end
	end

	// frame count clamped to 1..FRAMES
	always_comb begin
		if (frame_count_q == '0) begin
			limit = CMP_W'(1);
		end else if (CMP_W'(frame_count_q) > FRAMES_C) begin
			limit = FRAMES_C;
		end else begin
			limit = CMP_W'(frame_count_q);
		end
	end

	assign filled_m1 = filled_q - FILL_W'(1);

	// parallel tag compare and least recent search
	always_comb begin
		hit_idx  = '0;
		old_idx  = '0;
		hit_rank = '0;
		old_page = '0;
		for (int k = 0; k < FRAMES; k++) begin
			frame_vld[k] = FILL_W'(k) < filled_q;
			match[k]     = frame_vld[k] && (frame_page_q[k] == page_q);
			oldest[k]    = frame_vld[k] && (FILL_W'(rank_q[k]) == filled_m1);
			if (match[k]) begin
				hit_idx  = hit_idx | IDX_W'(k);
				hit_rank = hit_rank | rank_q[k];
			end
			if (oldest[k]) begin
				old_idx  = old_idx | IDX_W'(k);
				old_page = old_page | frame_page_q[k];
			end
		end
	end

	assign any_hit  = |match;
	assign can_fill = CMP_W'(filled_q) < limit;

	always_ff @(posedge clk) begin
		if (cmd.compare) begin
			page_s1 <= page_q;
			hit_s1  <= any_hit;
			fill_s1 <= !any_hit && can_fill;
			if (any_hit) begin
				slot_s1 <= hit_idx;
				lim_s1  <= hit_rank;
			end else if (can_fill) begin
				slot_s1 <= IDX_W'(filled_q);
				lim_s1  <= '0;
			end else begin
				slot_s1 <= old_idx;
				lim_s1  <= IDX_W'(filled_m1);
			end
			evicted_s1 <= (!any_hit && !can_fill) ? old_page : '0;
		end
	end

	assign do_replace = !hit_s1 && !fill_s1;
	assign fault_nxt  = (do_replace && fault_q != FAULT_MAX) ? fault_q + FAULT_W'(1) : fault_q;

	always_ff @(posedge clk) begin
		if (cmd.commit && !hit_s1) begin
			frame_page_q[slot_s1] <= page_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FRAMES; k++) begin
				rank_q[k] <= '0;
			end
			filled_q <= '0;
			fault_q  <= '0;
		end else if (cmd.commit) begin
			for (int k = 0; k < FRAMES; k++) begin
				if (IDX_W'(k) == slot_s1) begin
					rank_q[k] <= '0;
				end else if (frame_vld[k] && (fill_s1 || rank_q[k] < lim_s1)) begin
					rank_q[k] <= rank_q[k] + IDX_W'(1);
				end
			end
			if (fill_s1) begin
				filled_q <= filled_q + FILL_W'(1);
			end
			fault_q <= fault_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q       <= hit_s1;
			slot_q      <= SLOT_W'(slot_s1);
			replaced_q  <= do_replace;
			evicted_q   <= evicted_s1;
			fault_out_q <= fault_nxt;
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign replaced     = replaced_q;
	assign evicted_page = evicted_q;
	assign fault_total  = fault_out_q;

endmodule

/* design/lru_page_replacement_top.sv */
// the s1 registers hold the compare result, then the output register the result
//   once free; a new reference is taken only in idle or at commit, as compare of
//   the frame table, then the rank and frame update, share the one table
// reset: all frames empty, all ranks zero, fault count zero, frame_count 8
module lru_page_replacement_top
	import lrupr_pkg::*;
#(
	parameter int FRAMES = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PAGE_W-1:0]  page_number,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               hit,
	output logic [SLOT_W-1:0]  slot,
	output logic               replaced,
	output logic [PAGE_W-1:0]  evicted_page,
	output logic [FAULT_W-1:0] fault_total,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CFG_W-1:0]   frame_count
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	lrupr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lrupr_datapath #(
		.FRAMES (FRAMES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.page_number  (page_number),
		.cfg_valid    (cfg_valid),
		.frame_count  (frame_count),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.slot         (slot),
		.replaced     (replaced),
		.evicted_page (evicted_page),
		.fault_total  (fault_total)
	);

	a_hit_not_replaced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && replaced))
		else $error("hit and replaced both set");

	a_evicted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !replaced) |-> (evicted_page == '0))
		else $error("evicted page nonzero without replacement");

	a_fault_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && replaced) |-> (fault_total != '0))
		else $error("replacement with zero fault count");

	a_two_cycle_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken in consecutive cycles");

endmodule
